// ===== rtl/llc_pkg.sv =====
// ----------------------------------------------------------------------------
// llc_pkg
// Shared constants and controller/datapath interface types for the listing
// line checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package llc_pkg;

  // Largest program taken; later bytes are dropped and flagged.
  localparam int unsigned MAX_PROGRAM_BYTES = 28160;
  localparam int unsigned TAKEN_W           = 15;

  localparam int unsigned ADDR_W  = 17;
  localparam int unsigned START_W = 16;
  localparam int unsigned POS_W   = 4;

  // Configuration register indexes.
  localparam logic CFG_FORMAT_MODE   = 1'b0;
  localparam logic CFG_START_ADDRESS = 1'b1;

  // Format modes.
  localparam logic [1:0] MODE_SUM      = 2'd1;
  localparam logic [1:0] MODE_DOUBLE   = 2'd2;
  localparam logic [1:0] MODE_FLETCHER = 2'd3;
  localparam logic [1:0] MODE_RESET    = MODE_DOUBLE;

  // Commands from controller to datapath.
  typedef struct packed {
    logic byte_en;   // absorb the accepted input word
    logic pad_en;    // absorb one zero pad byte
    logic flush_en;  // emit the padded final line and clear the program
  } llc_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic emit_now;  // the input word closes a line or is a bare end marker
    logic pad_need;  // the input word is last and leaves a partial line
    logic line_full; // padding has reached the line length
  } llc_status_t;

endpackage

`default_nettype wire

// ===== rtl/llc_datapath.sv =====
// ----------------------------------------------------------------------------
// llc_datapath
// Line state, running sums, checksum finish and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module llc_datapath
  import llc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [START_W-1:0]  cfg_data,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_last_byte,
  input  wire llc_cmd_t            cmd,
  output llc_status_t              status,
  output logic [ADDR_W-1:0]        out_line_address,
  output logic [7:0]               out_checksum,
  output logic [POS_W-1:0]         out_real_bytes,
  output logic                     out_end_of_program,
  output logic                     out_was_truncated
);

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [3:0] hc;
    logic       anz;
  } sums_t;

  localparam logic [TAKEN_W-1:0] MAX_TAKEN = TAKEN_W'(MAX_PROGRAM_BYTES);

  // Reduce an 11-bit value modulo 255 by folding the upper bits.
  function automatic logic [7:0] mod255(input logic [10:0] a);
    logic [8:0] v;
    logic [8:0] w;
    v = 9'(a[7:0]) + 9'(a[10:8]);
    w = 9'(v[7:0]) + 9'(v[8]);
    mod255 = (w[7:0] == 8'hff) ? 8'd0 : w[7:0];
  endfunction

  function automatic logic [1:0] active_mode(input logic [1:0] fm);
    if (fm == MODE_SUM) active_mode = MODE_SUM;
    else if (fm == MODE_FLETCHER) active_mode = MODE_FLETCHER;
    else active_mode = MODE_DOUBLE;
  endfunction

  function automatic logic [POS_W-1:0] line_len(input logic [1:0] m);
    if (m == MODE_SUM) line_len = 4'd6;
    else if (m == MODE_FLETCHER) line_len = 4'd10;
    else line_len = 4'd8;
  endfunction

  function automatic sums_t seed(input logic [1:0] m, input logic [ADDR_W-1:0] ls,
                                 input sums_t s);
    sums_t r;
    r = s;
    if (m == MODE_SUM) begin
      r.lo = ls[7:0];
    end else if (m == MODE_DOUBLE) begin
      r.lo = mod255(11'(ls[7:0]) + 11'({ls[16:8], 1'b0}));
    end else begin
      r.lo = ls[7:0];
      r.hi = ls[15:8];
    end
    r.hc  = 4'd0;
    r.anz = (ls != '0);
    seed = r;
  endfunction

  function automatic sums_t absorb(input logic [1:0] m, input sums_t s,
                                   input logic [7:0] c);
    sums_t r;
    r = s;
    if (m == MODE_SUM) begin
      r.lo = s.lo + c;
    end else if (m == MODE_DOUBLE) begin
      r.lo = mod255(11'({s.lo, 1'b0}) + 11'(c));
    end else begin
      r.lo = s.lo + c;
      r.hi = s.hi + r.lo;
      r.hc = s.hc + 4'(c[7]);
    end
    if (c != 8'd0) r.anz = 1'b1;
    absorb = r;
  endfunction

  function automatic logic [7:0] finish(input logic [1:0] m, input sums_t s);
    logic [7:0] ck;
    if (m == MODE_SUM) begin
      ck = s.lo;
    end else if (m == MODE_DOUBLE) begin
      ck = (s.lo == 8'hff) ? 8'd0 : s.lo;
      if (ck == 8'd0 && s.anz) ck = 8'hff;
    end else begin
      ck = s.lo + s.hi + 8'(s.hc);
      if (ck == 8'd0) ck = 8'hff;
    end
    finish = ck;
  endfunction

  // Configuration and program state.
  logic [1:0]         fm_r;
  logic [START_W-1:0] sa_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]  ls_r, ls_nxt;
  logic [TAKEN_W-1:0] taken_r, taken_nxt;
  sums_t              sums_r, sums_nxt;
  logic               dropped_r, dropped_nxt;
  logic [POS_W-1:0]   real_r, real_nxt;

  // Output word.
  logic [ADDR_W-1:0]  oaddr_r, oaddr_nxt;
  logic [7:0]         ock_r, ock_nxt;
  logic [POS_W-1:0]   oreal_r, oreal_nxt;
  logic               oeop_r, oeop_nxt;
  logic               otrunc_r, otrunc_nxt;

  logic [1:0]         mode;
  logic [POS_W-1:0]   len;
  logic [ADDR_W-1:0]  ls0;
  logic               take;
  sums_t              base;
  sums_t              sums1;
  logic [POS_W-1:0]   pos1;
  logic               drop1;
  logic               full;

  always_comb begin
    mode  = active_mode(fm_r);
    len   = line_len(mode);
    ls0   = (taken_r == '0) ? ADDR_W'(sa_r) : ls_r;
    take  = (taken_r < MAX_TAKEN);
    base  = (pos_r == '0) ? seed(mode, ls0, sums_r) : sums_r;
    sums1 = take ? absorb(mode, base, in_data_byte) : sums_r;
    pos1  = take ? pos_r + 4'd1 : pos_r;
    drop1 = dropped_r | ~take;
    full  = (pos1 >= len);

    status.emit_now  = full || (in_last_byte && pos1 == '0);
    status.pad_need  = !full && in_last_byte && pos1 != '0;
    status.line_full = (pos_r >= len);

    pos_nxt     = pos_r;
    ls_nxt      = ls_r;
    taken_nxt   = taken_r;
    sums_nxt    = sums_r;
    dropped_nxt = dropped_r;
    real_nxt    = real_r;
    oaddr_nxt   = oaddr_r;
    ock_nxt     = ock_r;
    oreal_nxt   = oreal_r;
    oeop_nxt    = oeop_r;
    otrunc_nxt  = otrunc_r;

    if (cmd.byte_en) begin
      ls_nxt      = ls0;
      sums_nxt    = sums1;
      pos_nxt     = pos1;
      dropped_nxt = drop1;
      if (take) taken_nxt = taken_r + TAKEN_W'(1);
      if (full) begin
        oaddr_nxt  = ls0;
        ock_nxt    = finish(mode, sums1);
        oreal_nxt  = pos1;
        oeop_nxt   = in_last_byte;
        otrunc_nxt = drop1;
        ls_nxt     = ls0 + ADDR_W'(len);
        pos_nxt    = '0;
      end else if (in_last_byte && pos1 == '0) begin
        oaddr_nxt  = ls0;
        ock_nxt    = 8'd0;
        oreal_nxt  = '0;
        oeop_nxt   = 1'b1;
        otrunc_nxt = drop1;
      end
      if (status.pad_need) real_nxt = pos1;
      if (in_last_byte && !status.pad_need) begin
        pos_nxt     = '0;
        taken_nxt   = '0;
        sums_nxt    = '0;
        dropped_nxt = 1'b0;
      end
    end else if (cmd.pad_en) begin
      sums_nxt = absorb(mode, sums_r, 8'd0);
      pos_nxt  = pos_r + 4'd1;
    end else if (cmd.flush_en) begin
      oaddr_nxt   = ls_r;
      ock_nxt     = finish(mode, sums_r);
      oreal_nxt   = real_r;
      oeop_nxt    = 1'b1;
      otrunc_nxt  = dropped_r;
      ls_nxt      = ls_r + ADDR_W'(len);
      pos_nxt     = '0;
      taken_nxt   = '0;
      sums_nxt    = '0;
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fm_r      <= MODE_RESET;
      sa_r      <= '0;
      pos_r     <= '0;
      ls_r      <= '0;
      taken_r   <= '0;
      sums_r    <= '0;
      dropped_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_FORMAT_MODE) fm_r <= cfg_data[1:0];
      if (cfg_we && cfg_index == CFG_START_ADDRESS) sa_r <= cfg_data;
      pos_r     <= pos_nxt;
      ls_r      <= ls_nxt;
      taken_r   <= taken_nxt;
      sums_r    <= sums_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    real_r   <= real_nxt;
    oaddr_r  <= oaddr_nxt;
    ock_r    <= ock_nxt;
    oreal_r  <= oreal_nxt;
    oeop_r   <= oeop_nxt;
    otrunc_r <= otrunc_nxt;
  end

  assign out_line_address   = oaddr_r;
  assign out_checksum       = ock_r;
  assign out_real_bytes     = oreal_r;
  assign out_end_of_program = oeop_r;
  assign out_was_truncated  = otrunc_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 4'd10)
    else $error("line position out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_en |=> (pos_r == '0 && taken_r == '0 && !dropped_r))
    else $error("program state not cleared after final line");

endmodule

`default_nettype wire

// ===== rtl/llc_ctrl.sv =====
// ----------------------------------------------------------------------------
// llc_ctrl
// Sequencer: accepts input words, runs the zero padding of a final line and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module llc_ctrl
  import llc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire llc_status_t  status,
  output llc_cmd_t          cmd
);

  typedef enum logic {
    S_IDLE,
    S_PAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   load;

  always_comb begin
    out_free     = !out_valid_r || out_ready;
    in_ready     = (state_r == S_IDLE) && out_free;
    cmd.byte_en  = in_valid && in_ready;
    cmd.pad_en   = 1'b0;
    cmd.flush_en = 1'b0;
    state_nxt    = state_r;

    case (state_r)
      S_IDLE: begin
        if (cmd.byte_en && status.pad_need) state_nxt = S_PAD;
      end
      S_PAD: begin
        if (!status.line_full) begin
          cmd.pad_en = 1'b1;
        end else if (out_free) begin
          cmd.flush_en = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    load = (cmd.byte_en && status.emit_now) || cmd.flush_en;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_pad_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAD) |-> !in_ready)
    else $error("input accepted during padding");

  a_flush_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_en |-> out_free)
    else $error("final line overwrote a pending result");

  a_pad_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.byte_en && status.pad_need) |=> (state_r == S_PAD))
    else $error("partial final line not padded");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("result loaded without valid");

endmodule

`default_nettype wire

// ===== rtl/listing_line_checksum.sv =====
// ----------------------------------------------------------------------------
// listing_line_checksum
// Groups program bytes into listing lines and forms one checksum per line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one program byte per word plus
//   in_last_byte on the final byte. Bytes form lines of 6, 8 or 10 according
//   to format_mode; each full line produces one result word on the output
//   channel (out_valid/out_ready) with its address, checksum, byte count and
//   end/truncation flags. The last byte of a program always produces a word.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   format_mode (index 0) or start_address (index 1); write only when idle.
//   start_address is sampled on the first byte of each program.
// Timing:
//   One byte is absorbed per cycle unless padding runs or a stalled word
//   holds the output register; a result is registered and appears in the
//   cycle after the byte that closes its line. A final partial line is
//   padded in the sequencer at one zero byte per cycle, taking no input meanwhile.
//   Bytes past MAX_PROGRAM_BYTES are dropped and flagged in was_truncated.
// Reset (rst_n low, synchronous) clears the program state and sets mode 2
//   and start address 0. When the receiver stalls, the output register holds
//   its word and input is taken only once that word leaves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module listing_line_checksum
  import llc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [START_W-1:0]  cfg_data,
  // byte input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_last_byte,
  // line result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [ADDR_W-1:0]        out_line_address,
  output logic [7:0]               out_checksum,
  output logic [POS_W-1:0]         out_real_bytes,
  output logic                     out_end_of_program,
  output logic                     out_was_truncated
);

  llc_cmd_t    cmd;
  llc_status_t status;

  // Registers are always writable; the user writes them only between programs.
  assign cfg_ready = 1'b1;

  llc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  llc_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .cmd                (cmd),
    .status             (status),
    .out_line_address   (out_line_address),
    .out_checksum       (out_checksum),
    .out_real_bytes     (out_real_bytes),
    .out_end_of_program (out_end_of_program),
    .out_was_truncated  (out_was_truncated)
  );

endmodule

`default_nettype wire

// ===== bench/llc_line_board_pkg.sv =====
// ----------------------------------------------------------------------------
// llc_line_board_pkg
// Line tracker for the listing line checksum bench: follows the program byte
// stream, predicts every line word and checks the words the block returns.
// ----------------------------------------------------------------------------
package llc_line_board_pkg;

  import llc_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [7:0]        checksum;
    logic [POS_W-1:0]  real_bytes;
    logic              end_flag;
    logic              trunc_flag;
  } line_result_t;

  class line_checksum_board;

    logic [1:0]         format_mode;
    logic [START_W-1:0] start_address;
    logic [ADDR_W-1:0]  line_addr;
    int unsigned        line_pos;
    int unsigned        taken;
    int unsigned        sum_lo;
    int unsigned        sum_hi;
    int unsigned        high_cnt;
    bit                 any_nonzero;
    bit                 dropped;
    line_result_t       pending_lines[$];
    int unsigned        mismatches;

    function new();
      format_mode   = MODE_RESET;
      start_address = '0;
      line_addr     = '0;
      mismatches    = 0;
      clear_program();
    endfunction

    function void clear_program();
      line_pos    = 0;
      taken       = 0;
      sum_lo      = 0;
      sum_hi      = 0;
      high_cnt    = 0;
      any_nonzero = 1'b0;
      dropped     = 1'b0;
    endfunction

    function int unsigned pending();
      return pending_lines.size();
    endfunction

    function void write_register(logic index, logic [START_W-1:0] value);
      if (index == CFG_FORMAT_MODE) begin
        format_mode = value[1:0];
      end else begin
        start_address = value;
      end
    endfunction

    // Mode zero runs as the eight-byte mode.
    function logic [1:0] line_mode();
      if (format_mode == MODE_SUM || format_mode == MODE_FLETCHER) begin
        return format_mode;
      end
      return MODE_DOUBLE;
    endfunction

    function int unsigned line_len(logic [1:0] m);
      if (m == MODE_SUM) return 6;
      if (m == MODE_FLETCHER) return 10;
      return 8;
    endfunction

    function void seed_line(logic [1:0] m);
      int unsigned base;
      base = 32'(line_addr);
      if (m == MODE_SUM) begin
        sum_lo = base & 'hff;
      end else if (m == MODE_DOUBLE) begin
        sum_lo = ((base & 'hff) + 2 * (base >> 8)) % 255;
      end else begin
        sum_lo = base & 'hff;
        sum_hi = (base >> 8) & 'hff;
      end
      high_cnt    = 0;
      any_nonzero = (base != 0);
    endfunction

    function void absorb(logic [1:0] m, int unsigned c);
      if (m == MODE_SUM) begin
        sum_lo = (sum_lo + c) & 'hff;
      end else if (m == MODE_DOUBLE) begin
        sum_lo = (2 * sum_lo + c) % 255;
      end else begin
        sum_lo = (sum_lo + c) & 'hff;
        sum_hi = (sum_hi + sum_lo) & 'hff;
        if (c > 127) high_cnt = (high_cnt + 1) & 'hf;
      end
      if (c != 0) any_nonzero = 1'b1;
    endfunction

    function int unsigned line_checksum(logic [1:0] m);
      int unsigned ck;
      if (m == MODE_SUM) return sum_lo & 'hff;
      if (m == MODE_DOUBLE) begin
        ck = sum_lo % 255;
        if (ck == 0 && any_nonzero) ck = 255;
        return ck;
      end
      ck = (sum_lo + sum_hi + high_cnt) & 'hff;
      if (ck == 0) ck = 255;
      return ck;
    endfunction

    function void push_line(int unsigned ck, int unsigned nbytes, bit eop);
      line_result_t r;
      r.address    = line_addr;
      r.checksum   = ck[7:0];
      r.real_bytes = nbytes[POS_W-1:0];
      r.end_flag   = eop;
      r.trunc_flag = dropped;
      pending_lines.push_back(r);
    endfunction

    // Advance the line state by one accepted byte word.
    function void note_byte(logic [7:0] value, logic last);
      logic [1:0]  m;
      int unsigned len;
      int unsigned nbytes;
      m   = line_mode();
      len = line_len(m);
      if (taken == 0) line_addr = {1'b0, start_address};
      if (taken < MAX_PROGRAM_BYTES) begin
        if (line_pos == 0) seed_line(m);
        absorb(m, 32'(value));
        line_pos++;
        taken++;
      end else begin
        dropped = 1'b1;
      end
      if (line_pos >= len) begin
        push_line(line_checksum(m), line_pos, last);
        line_addr = line_addr + ADDR_W'(len);
        line_pos  = 0;
      end else if (last) begin
        if (line_pos > 0) begin
          nbytes = line_pos;
          while (line_pos < len) begin
            absorb(m, 0);
            line_pos++;
          end
          push_line(line_checksum(m), nbytes, 1'b1);
          line_addr = line_addr + ADDR_W'(len);
          line_pos  = 0;
        end else begin
          push_line(0, 0, 1'b1);
        end
      end
      if (last) clear_program();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_line(logic [ADDR_W-1:0] addr, logic [7:0] ck, logic [POS_W-1:0] nbytes,
                    logic eop, logic trunc);
      line_result_t want;
      if (pending_lines.size() == 0) begin
        report($sformatf("line word at %05h with no line due", addr));
        return;
      end
      want = pending_lines.pop_front();
      if (addr !== want.address)
        report($sformatf("line_address %05h, due %05h", addr, want.address));
      if (ck !== want.checksum)
        report($sformatf("checksum %02h at %05h, due %02h", ck, want.address, want.checksum));
      if (nbytes !== want.real_bytes)
        report($sformatf("real_bytes %0d at %05h, due %0d", nbytes, want.address,
                         want.real_bytes));
      if (eop !== want.end_flag)
        report($sformatf("end_of_program %b at %05h, due %b", eop, want.address,
                         want.end_flag));
      if (trunc !== want.trunc_flag)
        report($sformatf("was_truncated %b at %05h, due %b", trunc, want.address,
                         want.trunc_flag));
    endtask

  endclass

endpackage

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for listing_line_checksum. Streams program bytes through
// every format mode, start addresses at both ends of the range and mode
// changes inside an open line. A line tracker predicts each line word; both
// channels idle and stall at random, and one long receiver hold backs the
// block up into its input.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import llc_pkg::*;
  import llc_line_board_pkg::*;

  localparam int unsigned CLK_HALF      = 10;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  // a short final line is padded before its word shows
  localparam int unsigned SETTLE_CYCLES = 14;
  localparam int unsigned DRAIN_CYCLES  = 24;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned HOLD_PHASE    = 1;
  // long enough that the sender is still offering when the hold begins
  localparam int unsigned HOLD_PROG_LEN = 240;
  // longest correct silence: the long hold plus a long sender gap and padding
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam logic [1:0]  MODE_ZERO     = 2'd0;

  logic clk;
  logic rst_n;

  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [START_W-1:0] cfg_data;

  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_data_byte;
  logic               in_last_byte;

  logic               out_valid;
  logic               out_ready;
  logic [ADDR_W-1:0]  out_line_address;
  logic [7:0]         out_checksum;
  logic [POS_W-1:0]   out_real_bytes;
  logic               out_end_of_program;
  logic               out_was_truncated;

  line_checksum_board board = new();

  // idling knobs shared by the sender and the receiver
  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;

  listing_line_checksum dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_address  (out_line_address),
    .out_checksum      (out_checksum),
    .out_real_bytes    (out_real_bytes),
    .out_end_of_program(out_end_of_program),
    .out_was_truncated (out_was_truncated)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // --------------------------------------------------------------------------
  // Random shapes
  // --------------------------------------------------------------------------

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Lean on zero, 0xff and the 127/128 boundary that the high-byte count uses.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: return 8'h00;
      5, 6, 7:       return 8'hff;
      8:             return 8'h80;
      9:             return 8'h7f;
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(0, 6))
      0:       return MODE_ZERO;
      1, 2:    return MODE_SUM;
      3, 4:    return MODE_DOUBLE;
      default: return MODE_FLETCHER;
    endcase
  endfunction

  // Top-end addresses push line addresses past 16 bits.
  function automatic logic [START_W-1:0] pick_address();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hffff;
      2:       return 16'hfff8;
      default: return START_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Most programs are a few lines; some run to a couple of hundred bytes.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 30);
    if (r < 95) return $urandom_range(31, 80);
    return $urandom_range(81, 200);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one byte word and hold it until taken. Valid stays high after the
  // handshake until the next call or a register write drops it at the
  // following falling edge.
  task automatic send_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= value;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop the input, let every due line drain and padding finish, then write.
  task automatic set_register(input logic index, input logic [START_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: alternate ready-low and ready-high runs. A long hold request is
  // served here, counted in this process, while the sender keeps offering.
  initial begin : receiver
    int unsigned low_run;
    int unsigned high_run;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        low_run       = LONG_HOLD;
      end else begin
        low_run = pick_gap();
      end
      if (low_run != 0) begin
        out_ready <= 1'b0;
        repeat (low_run) @(negedge clk);
      end
      out_ready <= 1'b1;
      high_run = quiet ? 40 : $urandom_range(1, 20);
      repeat (high_run) @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge. Check outgoing line
  // words before noting the byte of the same edge; a line word is registered
  // and so always trails the byte that closed it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_line(out_line_address, out_checksum, out_real_bytes,
                         out_end_of_program, out_was_truncated);
      if (in_valid && in_ready) board.note_byte(in_data_byte, in_last_byte);
      if (cfg_valid && cfg_ready) board.write_register(cfg_index, cfg_data);
    end
  end

  // Watchdog: end the run once no word has moved on any channel for too long.
  initial begin : watchdog
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("FAIL listing_line_checksum");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_items;
    int unsigned phase;
    int unsigned n_prog;
    int unsigned len;
    bit          leave_open;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_FORMAT_MODE;
    cfg_data     = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings (eight-byte mode, address zero): an all-zero line keeps
    // checksum zero; then a lone 0xff ends the program in a padded final line.
    repeat (8) send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);

    // Six-byte mode from the top address: the second line starts past 16 bits.
    set_register(CFG_FORMAT_MODE, MODE_SUM);
    set_register(CFG_START_ADDRESS, 16'hffff);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(8'haa, 1'b1);

    // Ten-byte mode, leave seven bytes open, then switch to six-byte lines:
    // the next byte closes an eight-byte line. The new start address waits
    // for the next program.
    set_register(CFG_FORMAT_MODE, MODE_FLETCHER);
    set_register(CFG_START_ADDRESS, 16'h1234);
    send_byte(8'h81, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h3c, 1'b0);
    set_register(CFG_FORMAT_MODE, MODE_SUM);
    set_register(CFG_START_ADDRESS, 16'h0000);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h01, 1'b1);

    // Mode zero behaves as the eight-byte mode.
    set_register(CFG_FORMAT_MODE, MODE_ZERO);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'hc0, 1'b1);

    // Random programs, a fresh setting per phase. Now and then a program is
    // left open across a register write so the mode changes mid-line.
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0 || $urandom_range(0, 2) != 0) set_register(CFG_FORMAT_MODE, pick_mode());
      if ($urandom_range(0, 2) != 0) set_register(CFG_START_ADDRESS, pick_address());
      quiet = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
      // hold the receiver off while the sender streams a long program
      if (phase == HOLD_PHASE) long_hold_req = 1'b1;
      n_prog = $urandom_range(1, 4);
      for (int unsigned p = 0; p < n_prog; p++) begin
        len        = (phase == HOLD_PHASE) ? HOLD_PROG_LEN : pick_length();
        leave_open = (p == n_prog - 1) && ($urandom_range(0, 5) == 0) &&
                     (random_items + len < RANDOM_ITEMS);
        for (int unsigned i = 0; i < len; i++) begin
          send_byte(pick_byte(), !leave_open && (i == len - 1));
          random_items++;
        end
      end
      phase++;
    end

    // Drop the input, drain every due line, then give stray words a chance.
    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("PASS listing_line_checksum");
    end else begin
      $display("FAIL listing_line_checksum");
    end
    $finish;
  end

endmodule
